/* sv/cci_pkg.sv */
// ----------------------------------------------------------------------------
// cci_pkg
// shared types and constants of the cosine correction interpolator
// ----------------------------------------------------------------------------
package cci_pkg;

    // parameter defaults
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int VALUE_WIDTH_DEF  = 16;

    // table geometry: 181 entries, split into an even bank and an odd bank
    localparam int TABLE_LEN = 181;
    localparam int ROW_LEN   = (TABLE_LEN + 1) / 2;

    // bank numbering {axis, parity}
    localparam int BANK_WE_EVEN = 0;
    localparam int BANK_WE_ODD  = 1;
    localparam int BANK_SN_EVEN = 2;
    localparam int BANK_SN_ODD  = 3;
    localparam int NUM_BANKS    = 4;

    // angle limits in raw units (azimuth Q9.7, elevation Q7.7)
    localparam logic [15:0] AZ_QUAD1  = 16'd11520;
    localparam logic [15:0] AZ_QUAD2  = 16'd23040;
    localparam logic [15:0] AZ_QUAD3  = 16'd34560;
    localparam logic [15:0] AZ_LIMIT  = 16'd46080;
    localparam logic [13:0] EL_LIMIT  = 14'd11456;
    localparam logic [13:0] QUAD_SPAN = 14'd11520;
    localparam logic [7:0]  ELEV_LAST = 8'd180;
    localparam logic [7:0]  ELEV_PREV = 8'd179;
    localparam logic [7:0]  FRAC_ONE  = 8'd128;

    // final divide by 128*11520 = 2^15 * 45
    localparam int          DIV_SHIFT  = 15;
    localparam int          ROUND_HALF = 737280;
    localparam int          Y_WIDTH    = 21;
    localparam logic [20:0] SAT_Y      = 21'd1474560;
    localparam int          RECIP_W    = 22;
    localparam logic [21:0] RECIP_45   = 22'd2982617;
    localparam int          RECIP_SH   = 27;

    // result constants, signed Q2.14
    localparam logic [15:0] CORR_ONE     = 16'h4000;
    localparam logic [15:0] CORR_NEG_ONE = 16'hC000;
    localparam logic [15:0] CORR_MAX     = 16'h7FFF;
    localparam logic [15:0] CORR_ZERO    = 16'h0000;

    // configuration register indexes
    localparam logic CFG_SOUTH = 1'b0;
    localparam logic CFG_MASK  = 1'b1;

    typedef enum logic [2:0] {
        ST_INTERP   = 3'd0,
        ST_NO_TABLE = 3'd1,
        ST_ZENITH   = 3'd2,
        ST_AZ_RANGE = 3'd3,
        ST_LOADED   = 3'd4
    } t_status;

endpackage

/* sv/cci_ram.sv */
// ----------------------------------------------------------------------------
// cci_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cci_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 728
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/cosine_correction_interpolator_core.sv */
// ----------------------------------------------------------------------------
// cosine_correction_interpolator_core
// bilinear cosine correction from per-channel west-east / south-north tables
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output side is not stalled, and returns
// one result beat per input beat, in order, through the output register. A
// load beat (action 0) writes one table entry and returns status
// loaded; a compute beat (action 1) blends four table entries. Each table of
// each channel is split into an even-entry bank and an odd-entry bank, so the
// two west-east and two south-north reads of a compute beat hit four separate
// single-read-port rams and issue in the accepting cycle. The pipeline is
// ram read, elevation blend, azimuth blend, round and scale, reciprocal
// divide into the output register. Every stage keeps its own valid bit and
// moves up as soon as the stage ahead is free, so a waiting result holds back
// new input only once every stage is full. Loads write the ram at the
// accepting edge, so a compute beat right behind a load already reads the new
// value. Table contents have no reset; reading an entry that was never loaded
// is undefined. Configuration (hemisphere and table mask) is written through
// i_cfg_we, by the user only while no beat is in flight; the core does not check this.
// ----------------------------------------------------------------------------
module cosine_correction_interpolator_core #(
    parameter int NUM_CHANNELS = cci_pkg::NUM_CHANNELS_DEF,
    parameter int VALUE_WIDTH  = cci_pkg::VALUE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [2:0]         i_channel,
    input  logic               i_table_axis,
    input  logic [7:0]         i_entry_index,
    input  logic [15:0]        i_entry_value,
    input  logic [15:0]        i_azimuth,
    input  logic [13:0]        i_elevation,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_correction,
    output logic [2:0]         o_status
);

    import cci_pkg::*;

    localparam int VW    = VALUE_WIDTH;
    localparam int DEPTH = NUM_CHANNELS * ROW_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = VW + 7;            // elevation blend, value * 128
    localparam int PW    = CW + 14;           // azimuth blend products
    localparam int XW    = PW + 1;            // sum of both products
    localparam int YW    = XW - DIV_SHIFT;
    localparam int YXW   = (YW > Y_WIDTH) ? YW : Y_WIDTH;
    localparam int MW    = Y_WIDTH + RECIP_W;
    localparam logic [4:0] CH_LIMIT = 5'(NUM_CHANNELS);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic       r_south;
    logic [7:0] r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_south <= 1'b0;
            r_mask  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOUTH: r_south <= i_cfg_data[0];
                CFG_MASK:  r_mask  <= i_cfg_data;
                default:   r_south <= r_south;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage enables: a stage moves when the one ahead is empty or moving
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic en1, en2, en3, en4, en_out;

    assign en_out     = !r_out_valid || i_out_ready;
    assign en4        = !r_v4 || en_out;
    assign en3        = !r_v3 || en4;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_ready = en1;

    logic accept;
    assign accept = i_in_valid && en1;

    // ------------------------------------------------------------------
    // stage 0: classify, split angles, form bank addresses
    // ------------------------------------------------------------------
    logic          ch_ok;
    t_status       n_status;
    logic [1:0]    quad;
    logic [15:0]   quad_base;
    logic [13:0]   n_a;
    logic [6:0]    deg;
    logic [6:0]    frac;
    logic [1:0]    dir1, dir2, dir_we, dir_sn;
    logic          we_first;
    logic [7:0]    we_i0, we_i1, sn_i0, sn_i1;
    logic [7:0]    we_even, we_odd, sn_even, sn_odd;
    logic [AW-1:0] row_base;
    logic          load_ok;

    logic [AW-1:0] bank_raddr [NUM_BANKS];
    logic          bank_we    [NUM_BANKS];
    logic [VW-1:0] bank_rdata [NUM_BANKS];
    logic [AW-1:0] waddr;
    logic [VW-1:0] wdata;

    always_comb begin
        ch_ok = ({2'b00, i_channel} < CH_LIMIT);

        // result class, checked in priority order
        if (!i_action) begin
            n_status = ST_LOADED;
        end else if (!ch_ok || !r_mask[i_channel]) begin
            n_status = ST_NO_TABLE;
        end else if (i_elevation > EL_LIMIT) begin
            n_status = ST_ZENITH;
        end else if (i_azimuth >= AZ_LIMIT) begin
            n_status = ST_AZ_RANGE;
        end else begin
            n_status = ST_INTERP;
        end

        // azimuth quadrant and offset within it
        if (i_azimuth < AZ_QUAD1) begin
            quad      = 2'd0;
            quad_base = '0;
        end else if (i_azimuth < AZ_QUAD2) begin
            quad      = 2'd1;
            quad_base = AZ_QUAD1;
        end else if (i_azimuth < AZ_QUAD3) begin
            quad      = 2'd2;
            quad_base = AZ_QUAD2;
        end else begin
            quad      = 2'd3;
            quad_base = AZ_QUAD3;
        end
        n_a = 14'(i_azimuth - quad_base);

        deg  = i_elevation[13:7];
        frac = i_elevation[6:0];

        // directions 0 north, 1 east, 2 south, 3 west; southern sky mirrors
        dir1 = quad ^ {r_south, 1'b0};
        dir2 = 2'(quad + 2'd1) ^ {r_south, 1'b0};

        // neighbouring directions always alternate between the two tables
        we_first = dir1[0];
        dir_we   = we_first ? dir1 : dir2;
        dir_sn   = we_first ? dir2 : dir1;

        // east and north read from the far horizon end of their table
        if (!dir_we[1]) begin
            we_i0 = ELEV_LAST - {1'b0, deg};
            we_i1 = ELEV_PREV - {1'b0, deg};
        end else begin
            we_i0 = {1'b0, deg};
            we_i1 = 8'({1'b0, deg} + 8'd1);
        end
        if (!dir_sn[1]) begin
            sn_i0 = ELEV_LAST - {1'b0, deg};
            sn_i1 = ELEV_PREV - {1'b0, deg};
        end else begin
            sn_i0 = {1'b0, deg};
            sn_i1 = 8'({1'b0, deg} + 8'd1);
        end

        // the degree entry is odd exactly when the degree is odd
        we_even = deg[0] ? we_i1 : we_i0;
        we_odd  = deg[0] ? we_i0 : we_i1;
        sn_even = deg[0] ? sn_i1 : sn_i0;
        sn_odd  = deg[0] ? sn_i0 : sn_i1;

        row_base = AW'(32'(i_channel) * ROW_LEN);

        bank_raddr[BANK_WE_EVEN] = AW'(row_base + AW'(we_even[7:1]));
        bank_raddr[BANK_WE_ODD]  = AW'(row_base + AW'(we_odd[7:1]));
        bank_raddr[BANK_SN_EVEN] = AW'(row_base + AW'(sn_even[7:1]));
        bank_raddr[BANK_SN_ODD]  = AW'(row_base + AW'(sn_odd[7:1]));

        // table load
        load_ok = accept && !i_action && ch_ok && (i_entry_index < 8'(TABLE_LEN));
        waddr   = AW'(row_base + AW'(i_entry_index[7:1]));
        wdata   = VW'(i_entry_value);
        for (int b = 0; b < NUM_BANKS; b++) begin
            bank_we[b] = load_ok && (2'(b) == {i_table_axis, i_entry_index[0]});
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        cci_ram #(
            .WIDTH (VW),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[g]),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (en1),
            .i_raddr (bank_raddr[g]),
            .o_rdata (bank_rdata[g])
        );
    end

    // ------------------------------------------------------------------
    // stage 1: ram data arrives, blend along elevation
    // ------------------------------------------------------------------
    t_status     r_s1_status;
    logic [13:0] r_s1_a;
    logic [6:0]  r_s1_frac;
    logic        r_s1_odd;
    logic        r_s1_we_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_status   <= n_status;
            r_s1_a        <= n_a;
            r_s1_frac     <= frac;
            r_s1_odd      <= deg[0];
            r_s1_we_first <= we_first;
        end
    end

    logic [VW-1:0] we_p0, we_p1, sn_p0, sn_p1;
    logic [7:0]    w_lo;
    logic [CW-1:0] c_we, c_sn;

    always_comb begin
        we_p0 = r_s1_odd ? bank_rdata[BANK_WE_ODD]  : bank_rdata[BANK_WE_EVEN];
        we_p1 = r_s1_odd ? bank_rdata[BANK_WE_EVEN] : bank_rdata[BANK_WE_ODD];
        sn_p0 = r_s1_odd ? bank_rdata[BANK_SN_ODD]  : bank_rdata[BANK_SN_EVEN];
        sn_p1 = r_s1_odd ? bank_rdata[BANK_SN_EVEN] : bank_rdata[BANK_SN_ODD];
        w_lo  = FRAC_ONE - {1'b0, r_s1_frac};
        c_we  = CW'(CW'(we_p0) * CW'(w_lo) + CW'(we_p1) * CW'(r_s1_frac));
        c_sn  = CW'(CW'(sn_p0) * CW'(w_lo) + CW'(sn_p1) * CW'(r_s1_frac));
    end

    // ------------------------------------------------------------------
    // stage 2: blend along azimuth
    // ------------------------------------------------------------------
    t_status       r_s2_status;
    logic [13:0]   r_s2_a;
    logic [CW-1:0] r_s2_c1, r_s2_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_status <= r_s1_status;
            r_s2_a      <= r_s1_a;
            r_s2_c1     <= r_s1_we_first ? c_we : c_sn;
            r_s2_c2     <= r_s1_we_first ? c_sn : c_we;
        end
    end

    logic [PW-1:0] n_p1, n_p2;
    assign n_p1 = PW'(r_s2_c1) * PW'(QUAD_SPAN - r_s2_a);
    assign n_p2 = PW'(r_s2_c2) * PW'(r_s2_a);

    // ------------------------------------------------------------------
    // stage 3: sum, round, drop the power-of-two part of the divisor
    // ------------------------------------------------------------------
    t_status       r_s3_status;
    logic [PW-1:0] r_s3_p1, r_s3_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_status <= r_s2_status;
            r_s3_p1     <= n_p1;
            r_s3_p2     <= n_p2;
        end
    end

    logic [XW-1:0]  sum_x;
    logic [YW-1:0]  y_full;
    logic [YXW-1:0] y_ext;
    logic           n_sat;

    always_comb begin
        sum_x  = XW'(r_s3_p1) + XW'(r_s3_p2) + XW'(ROUND_HALF);
        y_full = sum_x[XW-1:DIV_SHIFT];
        y_ext  = YXW'(y_full);
        n_sat  = (y_ext >= YXW'(SAT_Y));
    end

    // ------------------------------------------------------------------
    // stage 4: divide by 45 through the reciprocal, into the output
    // ------------------------------------------------------------------
    t_status            r_s4_status;
    logic [Y_WIDTH-1:0] r_s4_y;
    logic               r_s4_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (en4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_status <= r_s3_status;
            r_s4_y      <= Y_WIDTH'(y_ext);
            r_s4_sat    <= n_sat;
        end
    end

    logic [MW-1:0] prod;
    logic [15:0]   n_corr;

    always_comb begin
        prod = MW'(r_s4_y) * MW'(RECIP_45);
        case (r_s4_status)
            ST_INTERP:   n_corr = r_s4_sat ? CORR_MAX : prod[RECIP_SH +: 16];
            ST_NO_TABLE: n_corr = CORR_ONE;
            ST_ZENITH:   n_corr = CORR_ONE;
            ST_AZ_RANGE: n_corr = CORR_NEG_ONE;
            default:     n_corr = CORR_ZERO;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [15:0] r_out_corr;
    t_status     r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_corr   <= n_corr;
            r_out_status <= r_s4_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_correction = signed'(r_out_corr);
    assign o_status     = 3'(r_out_status);

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the cosine correction interpolator core
// ----------------------------------------------------------------------------
// Fills both tables of the first and the last channel, then runs a short
// directed list and randomized load / compute traffic under changing
// hemisphere and table mask settings. Each accepted beat is run through a
// bench-side model of the table store and the bilinear blend. Every result
// beat is checked in order against the oldest expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import cci_pkg::*;

    localparam int NUM_CH      = NUM_CHANNELS_DEF;
    localparam int STORE_SLOTS = NUM_CH * 2 * TABLE_LEN;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 16;
    localparam int PHASE_BEATS = 125;
    localparam int MAX_PRINTS  = 100;

    // channels whose tables are fully loaded before any compute
    localparam logic [7:0] FILL_MASK  = 8'h81;
    localparam logic [2:0] FILL_CH_LO = 3'd0;
    localparam logic [2:0] FILL_CH_HI = 3'd7;

    // beat opcodes and table axes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;
    localparam logic AXIS_WE     = 1'b0;
    localparam logic AXIS_SN     = 1'b1;

    // compass directions, clockwise from north
    localparam int DIR_NORTH = 0;
    localparam int DIR_EAST  = 1;
    localparam int DIR_SOUTH = 2;
    localparam int DIR_WEST  = 3;

    localparam longint unsigned QUAD_RAW  = 11520;
    localparam longint unsigned BLEND_DEN = 128 * QUAD_RAW;

    typedef struct {
        logic        action;
        logic [2:0]  channel;
        logic        table_axis;
        logic [7:0]  entry_index;
        logic [15:0] entry_value;
        logic [15:0] azimuth;
        logic [13:0] elevation;
    } t_table_beat;

    typedef struct {
        logic signed [15:0] correction;
        t_status            status;
    } t_correction_beat;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic               i_cfg_index   = 1'b0;
    logic [7:0]         i_cfg_data    = 8'd0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic               i_action      = 1'b0;
    logic [2:0]         i_channel     = 3'd0;
    logic               i_table_axis  = 1'b0;
    logic [7:0]         i_entry_index = 8'd0;
    logic [15:0]        i_entry_value = 16'd0;
    logic [15:0]        i_azimuth     = 16'd0;
    logic [13:0]        i_elevation   = 14'd0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic signed [15:0] o_correction;
    logic [2:0]         o_status;

    cosine_correction_interpolator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_channel     (i_channel),
        .i_table_axis  (i_table_axis),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_azimuth     (i_azimuth),
        .i_elevation   (i_elevation),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_correction  (o_correction),
        .o_status      (o_status)
    );

    always #10 i_clk = ~i_clk;

    // bench copy of the tables and configuration
    bit [15:0]        entry_table [STORE_SLOTS];
    bit               hemisphere_south = 1'b0;
    bit [7:0]         channel_mask     = 8'd0;

    t_table_beat      pending_beats[$];
    t_correction_beat expected_results[$];
    t_table_beat      held_beat;
    t_correction_beat check_beat;

    int beats_queued  = 0;
    int beats_taken   = 0;
    int results_seen  = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------
    function automatic int unsigned table_slot(logic [2:0] ch, logic axis, int unsigned k);
        return (int'(ch) * 2 + int'(axis)) * TABLE_LEN + k;
    endfunction

    // entry seen from one compass direction at elevation degree k
    function automatic longint unsigned direction_entry(logic [2:0] ch, int unsigned dir,
                                                        int unsigned k);
        int unsigned d;
        d = hemisphere_south ? (dir ^ 2) : dir;
        case (d)
            DIR_NORTH: return entry_table[table_slot(ch, AXIS_SN, 180 - k)];
            DIR_EAST:  return entry_table[table_slot(ch, AXIS_WE, 180 - k)];
            DIR_SOUTH: return entry_table[table_slot(ch, AXIS_SN, k)];
            default:   return entry_table[table_slot(ch, AXIS_WE, k)];
        endcase
    endfunction

    // applies a load to the bench tables, or blends a compute beat
    function automatic t_correction_beat predict_correction(t_table_beat b);
        t_correction_beat  r;
        int unsigned       quad;
        int unsigned       deg;
        int unsigned       dir_a;
        int unsigned       dir_b;
        longint unsigned   frac_az;
        longint unsigned   frac_el;
        longint unsigned   blend_a;
        longint unsigned   blend_b;
        longint unsigned   q14;
        if (b.action == ACT_LOAD) begin
            // out-of-range index writes nothing but still answers
            if (b.entry_index <= ELEV_LAST && int'(b.channel) < NUM_CH) begin
                entry_table[table_slot(b.channel, b.table_axis, b.entry_index)] = b.entry_value;
            end
            r.correction = CORR_ZERO;
            r.status     = ST_LOADED;
        end else if (int'(b.channel) >= NUM_CH || !channel_mask[b.channel]) begin
            r.correction = CORR_ONE;
            r.status     = ST_NO_TABLE;
        end else if (b.elevation > EL_LIMIT) begin
            r.correction = CORR_ONE;
            r.status     = ST_ZENITH;
        end else if (b.azimuth >= AZ_LIMIT) begin
            r.correction = CORR_NEG_ONE;
            r.status     = ST_AZ_RANGE;
        end else begin
            quad    = b.azimuth / QUAD_RAW;
            frac_az = b.azimuth - quad * QUAD_RAW;
            deg     = b.elevation[13:7];
            frac_el = b.elevation[6:0];
            dir_a   = quad;
            dir_b   = (quad + 1) % 4;
            blend_a = direction_entry(b.channel, dir_a, deg) * (128 - frac_el)
                    + direction_entry(b.channel, dir_a, deg + 1) * frac_el;
            blend_b = direction_entry(b.channel, dir_b, deg) * (128 - frac_el)
                    + direction_entry(b.channel, dir_b, deg + 1) * frac_el;
            q14 = (blend_a * (QUAD_RAW - frac_az) + blend_b * frac_az + BLEND_DEN / 2)
                / BLEND_DEN;
            if (q14 > 32767) q14 = 32767;
            r.correction = q14[15:0];
            r.status     = ST_INTERP;
        end
        return r;
    endfunction

    task automatic mismatch_report(string what, int got, int want);
        if (fail_count < MAX_PRINTS) begin
            $display("mismatch at result %0d: %s got %0d want %0d",
                     results_seen, what, got, want);
        end
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // driver: raises valid from the pending queue and holds it until taken
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // beat accepted at this edge: model it before loading the next
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_correction(held_beat));
                beats_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    held_beat = pending_beats.pop_front();
                    i_action      <= held_beat.action;
                    i_channel     <= held_beat.channel;
                    i_table_axis  <= held_beat.table_axis;
                    i_entry_index <= held_beat.entry_index;
                    i_entry_value <= held_beat.entry_value;
                    i_azimuth     <= held_beat.azimuth;
                    i_elevation   <= held_beat.elevation;
                    i_in_valid    <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random backpressure, in-order compare of each result beat
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_report("unexpected beat, correction", o_correction, 0);
                end else begin
                    check_beat = expected_results.pop_front();
                    if (o_correction !== check_beat.correction) begin
                        mismatch_report("correction", o_correction, check_beat.correction);
                    end
                    if (o_status !== check_beat.status) begin
                        mismatch_report("status", o_status, check_beat.status);
                    end
                end
                results_seen++;
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic write_config(logic index, logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (index == CFG_SOUTH) hemisphere_south = data[0];
        else channel_mask = data;
    endtask

    // every beat taken and every result back
    task automatic wait_drained();
        @(negedge i_clk);
        while (beats_taken != beats_queued || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_entry_value();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1, 2:    return 16'($urandom);
            default: return 16'($urandom_range(20000, 12000));
        endcase
    endfunction

    task automatic queue_load(logic [2:0] ch, logic axis, logic [7:0] idx, logic [15:0] val);
        t_table_beat b;
        b.action      = ACT_LOAD;
        b.channel     = ch;
        b.table_axis  = axis;
        b.entry_index = idx;
        b.entry_value = val;
        b.azimuth     = 16'($urandom);
        b.elevation   = 14'($urandom);
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_compute(logic [2:0] ch, logic [15:0] az, logic [13:0] el);
        t_table_beat b;
        b.action      = ACT_COMPUTE;
        b.channel     = ch;
        b.table_axis  = 1'($urandom);
        b.entry_index = 8'($urandom);
        b.entry_value = 16'($urandom);
        b.azimuth     = az;
        b.elevation   = el;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // mostly well-formed computes, loads sprinkled in, some out-of-range
    task automatic queue_random(int count);
        logic [15:0] az;
        logic [13:0] el;
        logic [2:0]  ch;
        repeat (count) begin
            if ($urandom_range(3) == 0) begin
                queue_load(3'($urandom), 1'($urandom),
                           ($urandom_range(9) == 0) ? 8'($urandom_range(255, 181))
                                                    : 8'($urandom_range(180)),
                           pick_entry_value());
            end else begin
                case ($urandom_range(19))
                    0:       az = 16'($urandom_range(65535, 46080));
                    1:       az = 16'($urandom_range(3) * 11520);
                    2:       az = 16'($urandom_range(4) * 11520 - 1);
                    default: az = 16'($urandom_range(46079));
                endcase
                case ($urandom_range(19))
                    0:       el = 14'($urandom_range(16383, 11457));
                    1:       el = 14'($urandom_range(89) * 128);
                    2:       el = 14'($urandom_range(89) * 128 + 127);
                    default: el = 14'($urandom_range(11456));
                endcase
                // an unfilled channel is only asked while its table bit is clear
                ch = 3'($urandom);
                if (channel_mask[ch] && !FILL_MASK[ch]) begin
                    ch = $urandom_range(1) ? FILL_CH_HI : FILL_CH_LO;
                end
                queue_compute(ch, az, el);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 50;
        write_config(CFG_SOUTH, 8'd0);
        write_config(CFG_MASK, 8'hFF);

        // fill the tables of the chosen channels, the only ones ever blended
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (FILL_MASK[ch]) begin
                for (int ax = 0; ax < 2; ax++) begin
                    for (int k = 0; k < TABLE_LEN; k++) begin
                        queue_load(3'(ch), 1'(ax), 8'(k), pick_entry_value());
                    end
                end
            end
        end
        wait_drained();

        // directed list, only the filled channels have tables
        write_config(CFG_MASK, FILL_MASK);
        queue_compute(FILL_CH_LO, 16'd0, 14'd0);
        queue_compute(FILL_CH_HI, 16'd11519, 14'd11456); // last point before zenith limit
        queue_compute(FILL_CH_HI, 16'd11520, 14'd127);
        queue_compute(FILL_CH_LO, 16'd23040, 14'd128);
        queue_compute(FILL_CH_HI, 16'd34560, 14'd11455);
        queue_compute(FILL_CH_HI, 16'd46079, 14'd5000);  // top of the last quadrant
        queue_compute(FILL_CH_LO, 16'd46080, 14'd0);     // azimuth out of range
        queue_compute(FILL_CH_LO, 16'hFFFF, 14'd100);
        queue_compute(FILL_CH_HI, 16'd1000, 14'd11457);  // just above the zenith limit
        queue_compute(FILL_CH_LO, 16'd46080, 14'h3FFF);  // zenith wins over azimuth
        queue_compute(3'd5, 16'd100, 14'd100);           // no table
        queue_compute(3'd3, 16'hFFFF, 14'h3FFF);         // no table wins over all
        // west horizon alone drives q3 at a=0, e=0: full scale saturates
        queue_load(FILL_CH_LO, AXIS_WE, 8'd0, 16'hFFFF);
        queue_compute(FILL_CH_LO, 16'd34560, 14'd0);
        queue_load(FILL_CH_LO, AXIS_WE, 8'd0, 16'h0000);
        queue_compute(FILL_CH_LO, 16'd34560, 14'd0);
        // index past the table end must not spill into the next table
        queue_load(FILL_CH_LO, AXIS_WE, 8'd181, 16'h1234);
        queue_compute(FILL_CH_LO, 16'd23040, 14'd0);
        queue_load(FILL_CH_HI, AXIS_SN, 8'd180, 16'd20000);
        queue_load(FILL_CH_HI, AXIS_SN, 8'hFF, 16'hFFFF);
        queue_compute(FILL_CH_HI, 16'd0, 14'd0);         // north horizon is entry 180
        queue_compute(FILL_CH_HI, 16'd5760, 14'd64);
        wait_drained();

        // random traffic, settings and idling change only while drained
        for (int phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin
                    send_idle_pct = 11;
                    recv_idle_pct = 50;
                end
                1: begin
                    send_idle_pct = 50;
                    recv_idle_pct = 11;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                0: begin
                    write_config(CFG_SOUTH, 8'd0);
                    write_config(CFG_MASK, 8'hFF);
                end
                1: begin
                    write_config(CFG_SOUTH, 8'd1);
                    write_config(CFG_MASK, 8'hFF);
                end
                2: begin
                    write_config(CFG_SOUTH, 8'd1);
                    write_config(CFG_MASK, 8'($urandom));
                end
                3: begin
                    write_config(CFG_SOUTH, 8'd0);
                    write_config(CFG_MASK, 8'h00);
                end
                4: begin
                    write_config(CFG_SOUTH, 8'd1);
                    write_config(CFG_MASK, 8'hA5);
                end
                default: begin
                    write_config(CFG_SOUTH, 8'd0);
                    write_config(CFG_MASK, 8'($urandom));
                end
            endcase
            queue_random(PHASE_BEATS);
            wait_drained();
        end

        // catch any stray beat after the last expected one
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
